### hdl/mtmc_pkg.sv
// ----------------------------------------------------------------------------
// mtmc_pkg
// Shared types and constants for the multi-tap mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mtmc_pkg;

   localparam int TimeWidth = 16;
   localparam int DivWidth  = 7;
   localparam int TapWidth  = 8;
   localparam int DataWidth = 8;
   localparam int IndexWidth = 2;

   localparam logic [TimeWidth-1:0] HoldThresholdReset = 16'd500;
   localparam logic [TimeWidth-1:0] TapTimeoutReset    = 16'd200;
   localparam logic [DivWidth-1:0]  ScrollDivisorReset = 7'd10;
   localparam logic [TapWidth-1:0]  TapMax             = 8'd255;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_PRESS   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_MOTION  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_MOTION = 2'd0,
      KIND_F13    = 2'd1,
      KIND_F15    = 2'd2,
      KIND_DRAG   = 2'd3
   } kind_type;

   typedef enum logic [IndexWidth-1:0] {
      REG_HOLD_THRESHOLD = 2'd0,
      REG_TAP_TIMEOUT    = 2'd1,
      REG_SCROLL_DIVISOR = 2'd2,
      REG_UNUSED         = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0] hold_threshold_ms;
      logic [TimeWidth-1:0] tap_timeout_ms;
      logic [DivWidth-1:0]  scroll_divisor;
   } cfg_type;

   typedef struct packed {
      logic [TimeWidth-1:0]        ms_counter;
      logic [TimeWidth-1:0]        press_time;
      logic [TimeWidth-1:0]        last_tap_time;
      logic [TapWidth-1:0]         taps_pending;
      logic                        button_down;
      logic                        in_3d_mode;
      logic                        pan_axis;
      logic signed [TimeWidth-1:0] accum_horizontal;
      logic signed [TimeWidth-1:0] accum_vertical;
   } state_type;

   typedef struct packed {
      kind_type                    event_kind;
      logic signed [DataWidth-1:0] out_dx;
      logic signed [DataWidth-1:0] out_dy;
      logic signed [DataWidth-1:0] out_h;
      logic signed [DataWidth-1:0] out_v;
   } result_type;

endpackage

`default_nettype wire

### hdl/mtmc_core.sv
// ----------------------------------------------------------------------------
// mtmc_core
// Next-state and result logic for one word: tap timing, mode changes and
// scroll accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmc_core (
   input  wire mtmc_pkg::cfg_type              cfg,
   input  wire mtmc_pkg::state_type            state,
   input  wire mtmc_pkg::op_type               op,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0] dx,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0] dy,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0] wheel_h,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0] wheel_v,
   output mtmc_pkg::state_type                 state_next,
   output logic                                res_valid,
   output mtmc_pkg::result_type                res
);

   localparam int TW = mtmc_pkg::TimeWidth;

   logic [TW-1:0]        ms_next;
   logic [TW-1:0]        idle;
   logic [TW-1:0]        held;
   logic                 fire;
   logic                 want_pan;
   logic signed [TW-1:0] div;
   logic signed [TW:0]   sum_h;
   logic signed [TW:0]   sum_v;
   logic signed [TW-1:0] sat_h;
   logic signed [TW-1:0] sat_v;
   logic signed [1:0]    tick_h;
   logic signed [1:0]    tick_v;
   logic signed [TW-1:0] acc_h;
   logic signed [TW-1:0] acc_v;
   mtmc_pkg::kind_type   axis_kind;

   always_comb begin
      ms_next   = state.ms_counter + 16'd1;
      idle      = ms_next - state.last_tap_time;
      held      = state.ms_counter - state.press_time;
      fire      = (state.taps_pending != '0) && !state.button_down &&
                  (idle > cfg.tap_timeout_ms);
      want_pan  = (state.taps_pending >= 8'd3);
      axis_kind = state.pan_axis ? mtmc_pkg::KIND_F15 : mtmc_pkg::KIND_F13;

      div = (cfg.scroll_divisor == '0) ? 16'sd1 : $signed({9'd0, cfg.scroll_divisor});

      sum_h = {state.accum_horizontal[TW-1], state.accum_horizontal} +
              {{(TW+1-mtmc_pkg::DataWidth){dx[mtmc_pkg::DataWidth-1]}}, dx};
      sum_v = {state.accum_vertical[TW-1], state.accum_vertical} +
              {{(TW+1-mtmc_pkg::DataWidth){dy[mtmc_pkg::DataWidth-1]}}, dy};
      if (sum_h[TW] != sum_h[TW-1]) begin
         sat_h = sum_h[TW] ? 16'sh8000 : 16'sh7fff;
      end else begin
         sat_h = sum_h[TW-1:0];
      end
      if (sum_v[TW] != sum_v[TW-1]) begin
         sat_v = sum_v[TW] ? 16'sh8000 : 16'sh7fff;
      end else begin
         sat_v = sum_v[TW-1:0];
      end

      if (sat_h >= div) begin
         acc_h  = sat_h - div;
         tick_h = 2'sd1;
      end else if (sat_h <= -div) begin
         acc_h  = sat_h + div;
         tick_h = -2'sd1;
      end else begin
         acc_h  = sat_h;
         tick_h = 2'sd0;
      end
      if (sat_v >= div) begin
         acc_v  = sat_v - div;
         tick_v = -2'sd1;
      end else if (sat_v <= -div) begin
         acc_v  = sat_v + div;
         tick_v = 2'sd1;
      end else begin
         acc_v  = sat_v;
         tick_v = 2'sd0;
      end

      state_next = state;
      res_valid  = 1'b0;
      res        = '{event_kind: mtmc_pkg::KIND_MOTION, default: '0};

      case (op)
         mtmc_pkg::OP_TICK: begin
            state_next.ms_counter = ms_next;
            if (fire) begin
               res_valid = 1'b1;
               state_next.taps_pending = '0;
               if (state.taps_pending == 8'd1) begin
                  if (state.in_3d_mode) begin
                     state_next.in_3d_mode = 1'b0;
                     res.event_kind = axis_kind;
                  end else begin
                     res.event_kind = mtmc_pkg::KIND_DRAG;
                  end
               end else begin
                  if (!state.in_3d_mode) begin
                     state_next.in_3d_mode = 1'b1;
                     state_next.pan_axis   = want_pan;
                  end else if (state.pan_axis == want_pan) begin
                     state_next.in_3d_mode = 1'b0;
                  end else begin
                     state_next.pan_axis = want_pan;
                  end
                  res.event_kind = want_pan ? mtmc_pkg::KIND_F15 : mtmc_pkg::KIND_F13;
               end
            end
         end
         mtmc_pkg::OP_PRESS: begin
            state_next.press_time  = state.ms_counter;
            state_next.button_down = 1'b1;
         end
         mtmc_pkg::OP_RELEASE: begin
            state_next.button_down = 1'b0;
            if (held < cfg.hold_threshold_ms) begin
               if (state.taps_pending != mtmc_pkg::TapMax) begin
                  state_next.taps_pending = state.taps_pending + 8'd1;
               end
               state_next.last_tap_time = state.ms_counter;
            end else begin
               state_next.taps_pending = '0;
               if (state.in_3d_mode) begin
                  state_next.in_3d_mode = 1'b0;
                  res_valid      = 1'b1;
                  res.event_kind = axis_kind;
               end
            end
         end
         mtmc_pkg::OP_MOTION: begin
            res_valid = 1'b1;
            if (!state.in_3d_mode) begin
               res.out_dx = dx;
               res.out_dy = dy;
               res.out_h  = wheel_h;
               res.out_v  = wheel_v;
            end else begin
               state_next.accum_horizontal = acc_h;
               state_next.accum_vertical   = acc_v;
               res.out_h = {{(mtmc_pkg::DataWidth-2){tick_h[1]}}, tick_h};
               res.out_v = {{(mtmc_pkg::DataWidth-2){tick_v[1]}}, tick_v};
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

`default_nettype wire

### hdl/mtmc_skid.sv
// ----------------------------------------------------------------------------
// mtmc_skid
// Output register with a skid stage, so a word can be taken in while the
// previous result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mtmc_skid (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire mtmc_pkg::result_type  push_data,
   output logic                       full,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output mtmc_pkg::result_type       out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   mtmc_pkg::result_type out_data_ff, out_data_in;
   mtmc_pkg::result_type skid_data_ff, skid_data_in;
   logic                 take;

   always_comb begin
      take          = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = push;
         out_data_in  = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

### hdl/multi_tap_mode_controller.sv
// ----------------------------------------------------------------------------
// multi_tap_mode_controller
// Single-button tap/hold mode controller for a trackball with 3D scroll mode.
// A result goes to the output register, or to the skid stage while rsp_ stalls.
// Throughput: one word per cycle; the output skid stage keeps req_ready high
// unless two results are waiting.
// Reset clears all timers, tap count, mode and accumulators, and loads the
// register defaults (hold 500, timeout 200, divisor 10).
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tap_mode_controller (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [1:0]                             req_op,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0]  req_dx,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0]  req_dy,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0]  req_wheel_h,
   input  wire logic signed [mtmc_pkg::DataWidth-1:0]  req_wheel_v,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [1:0]                                  rsp_event_kind,
   output logic signed [mtmc_pkg::DataWidth-1:0]       rsp_out_dx,
   output logic signed [mtmc_pkg::DataWidth-1:0]       rsp_out_dy,
   output logic signed [mtmc_pkg::DataWidth-1:0]       rsp_out_h,
   output logic signed [mtmc_pkg::DataWidth-1:0]       rsp_out_v,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [mtmc_pkg::IndexWidth-1:0]        csr_index,
   input  wire logic [mtmc_pkg::TimeWidth-1:0]         csr_wdata
);

   mtmc_pkg::cfg_type    cfg_ff, cfg_in;
   mtmc_pkg::state_type  state_ff, state_in, state_next;
   mtmc_pkg::result_type res, rsp_data;
   logic                 res_valid;
   logic                 accept;
   logic                 skid_full;

   assign accept    = req_valid && req_ready;
   assign req_ready = !skid_full;
   assign csr_ready = 1'b1;

   mtmc_core u_core (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .op         (mtmc_pkg::op_type'(req_op)),
      .dx         (req_dx),
      .dy         (req_dy),
      .wheel_h    (req_wheel_h),
      .wheel_v    (req_wheel_v),
      .state_next (state_next),
      .res_valid  (res_valid),
      .res        (res)
   );

   mtmc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_data (res),
      .full      (skid_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   always_comb begin
      state_in = accept ? state_next : state_ff;
      cfg_in   = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (mtmc_pkg::reg_index_type'(csr_index))
            mtmc_pkg::REG_HOLD_THRESHOLD: cfg_in.hold_threshold_ms = csr_wdata;
            mtmc_pkg::REG_TAP_TIMEOUT:    cfg_in.tap_timeout_ms    = csr_wdata;
            mtmc_pkg::REG_SCROLL_DIVISOR: begin
               cfg_in.scroll_divisor = csr_wdata[mtmc_pkg::DivWidth-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         cfg_ff   <= '{hold_threshold_ms: mtmc_pkg::HoldThresholdReset,
                       tap_timeout_ms:    mtmc_pkg::TapTimeoutReset,
                       scroll_divisor:    mtmc_pkg::ScrollDivisorReset};
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
   end

   assign rsp_event_kind = rsp_data.event_kind;
   assign rsp_out_dx     = rsp_data.out_dx;
   assign rsp_out_dy     = rsp_data.out_dy;
   assign rsp_out_h      = rsp_data.out_h;
   assign rsp_out_v      = rsp_data.out_v;

   a_skid_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid stage holds a word while the output is empty");

   a_press_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == mtmc_pkg::OP_PRESS) |-> !res_valid)
      else $error("press produced a result");

   a_dispatch_clears_taps: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == mtmc_pkg::OP_TICK && res_valid) |=> state_ff.taps_pending == '0)
      else $error("tap count not cleared after dispatch");

   a_result_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (accept && res_valid) |=> rsp_valid)
      else $error("accepted result did not reach the output");

endmodule

`default_nettype wire
